[design/ray_rect_slab_intersect_assert.svh]
// Assertion macros used by the finish stage of the ray and rectangle intersection design.
`ifndef RAY_RECT_SLAB_INTERSECT_ASSERT_SVH
`define RAY_RECT_SLAB_INTERSECT_ASSERT_SVH

// The check must hold in the same cycle as the condition.
`define RRSI_ASSERT_NOW(name, cond, check, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// The check must hold in the cycle after the condition.
`define RRSI_ASSERT_NEXT(name, cond, check, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`endif

[design/rrsi_pkg.sv]
// Types, constants and helper functions of the ray and rectangle intersection pipeline.
`default_nettype none

package rrsi_pkg;

   localparam int Q_FRAC    = 16;
   localparam int NUM_W     = 34;
   localparam int NUM_MAG_W = NUM_W - 1;
   localparam int DEN_W     = 32;
   localparam int QUO_W     = NUM_MAG_W + Q_FRAC;
   localparam int T_W       = 58;
   localparam int SQ_W      = 64;
   localparam int SQRT_STEPS = SQ_W / 2;

   localparam logic signed [T_W-1:0] T_INF = 58'sh100000000000000;

   localparam logic [2:0] NORM_NONE  = 3'd0;
   localparam logic [2:0] NORM_POS_X = 3'd1;
   localparam logic [2:0] NORM_NEG_X = 3'd2;
   localparam logic [2:0] NORM_POS_Y = 3'd3;
   localparam logic [2:0] NORM_NEG_Y = 3'd4;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] box_left;
      logic signed [31:0] box_bottom;
      logic [30:0]        box_width;
      logic [30:0]        box_height;
   } req_type;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] t_near;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic [2:0]         face_normal;
      logic signed [31:0] pen_depth;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } ray_type;

   typedef struct packed {
      logic                 neg;
      logic                 zero;
      logic [NUM_MAG_W-1:0] mag;
   } num_type;

   typedef struct packed {
      num_type          lo;
      num_type          hi;
      logic             d_neg;
      logic             d_zero;
      logic [DEN_W-1:0] d_mag;
   } slab_in_type;

   typedef struct packed {
      ray_type         ray;
      slab_in_type     sx;
      slab_in_type     sy;
      logic [SQ_W-1:0] sq_sum;
   } prep_type;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [QUO_W-1:0] quo;
   } quo_type;

   typedef struct packed {
      quo_type lo;
      quo_type hi;
      logic    d_neg;
      logic    d_zero;
   } slab_quo_type;

   typedef struct packed {
      ray_type      ray;
      slab_quo_type sx;
      slab_quo_type sy;
      logic [31:0]  mag;
   } iter_type;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] t;
      logic [2:0]         normal;
      ray_type            ray;
      logic [31:0]        mag;
   } hit_type;

   // Clamps a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh0000000080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/rrsi_prep.sv]
// Front stages: slab numerators, their magnitudes and the squared direction length.
`default_nettype none

module rrsi_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rrsi_pkg::req_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rrsi_pkg::prep_type out_data
);
   import rrsi_pkg::*;

   typedef struct packed {
      ray_type                 ray;
      logic signed [NUM_W-1:0] nx_lo;
      logic signed [NUM_W-1:0] nx_hi;
      logic signed [NUM_W-1:0] ny_lo;
      logic signed [NUM_W-1:0] ny_hi;
      logic [SQ_W-1:0]         sq_x;
      logic [SQ_W-1:0]         sq_y;
      logic [SQ_W-1:0]         sq_z;
   } diff_type;

   function automatic logic signed [NUM_W-1:0] ext_num(input logic signed [31:0] v);
      return {{(NUM_W-32){v[31]}}, v};
   endfunction

   function automatic num_type split_num(input logic signed [NUM_W-1:0] n);
      logic [NUM_W-1:0] a;
      num_type          r;
      a = n[NUM_W-1] ? NUM_W'(-n) : n;
      r.neg  = n[NUM_W-1];
      r.zero = (n == '0);
      r.mag  = a[NUM_MAG_W-1:0];
      return r;
   endfunction

   logic     v1_ff, v1_in, v2_ff, v2_in;
   logic     en1, en2;
   diff_type d1_ff, d1_in;
   prep_type d2_ff, d2_in;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign v1_in    = in_valid;
   assign v2_in    = v1_ff;

   always_comb begin
      logic signed [63:0] dx, dy, dz;
      dx = in_data.dir_x;
      dy = in_data.dir_y;
      dz = in_data.dir_z;
      d1_in.ray.origin_x = in_data.origin_x;
      d1_in.ray.origin_y = in_data.origin_y;
      d1_in.ray.origin_z = in_data.origin_z;
      d1_in.ray.dir_x    = in_data.dir_x;
      d1_in.ray.dir_y    = in_data.dir_y;
      d1_in.ray.dir_z    = in_data.dir_z;
      d1_in.nx_lo = ext_num(in_data.box_left) - ext_num(in_data.origin_x);
      d1_in.nx_hi = ext_num(in_data.box_left) + $signed({3'b000, in_data.box_width})
                    - ext_num(in_data.origin_x);
      d1_in.ny_lo = ext_num(in_data.box_bottom) - ext_num(in_data.origin_y);
      d1_in.ny_hi = ext_num(in_data.box_bottom) + $signed({3'b000, in_data.box_height})
                    - ext_num(in_data.origin_y);
      d1_in.sq_x = dx * dx;
      d1_in.sq_y = dy * dy;
      d1_in.sq_z = dz * dz;
   end

   always_comb begin
      d2_in.ray       = d1_ff.ray;
      d2_in.sx.lo     = split_num(d1_ff.nx_lo);
      d2_in.sx.hi     = split_num(d1_ff.nx_hi);
      d2_in.sx.d_neg  = d1_ff.ray.dir_x[31];
      d2_in.sx.d_zero = (d1_ff.ray.dir_x == '0);
      d2_in.sx.d_mag  = d1_ff.ray.dir_x[31] ? DEN_W'(-d1_ff.ray.dir_x) : d1_ff.ray.dir_x;
      d2_in.sy.lo     = split_num(d1_ff.ny_lo);
      d2_in.sy.hi     = split_num(d1_ff.ny_hi);
      d2_in.sy.d_neg  = d1_ff.ray.dir_y[31];
      d2_in.sy.d_zero = (d1_ff.ray.dir_y == '0);
      d2_in.sy.d_mag  = d1_ff.ray.dir_y[31] ? DEN_W'(-d1_ff.ray.dir_y) : d1_ff.ray.dir_y;
      d2_in.sq_sum    = d1_ff.sq_x + d1_ff.sq_y + d1_ff.sq_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= v1_in;
         end
         if (en2) begin
            v2_ff <= v2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff <= d1_in;
      end
      if (en2) begin
         d2_ff <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = d2_ff;

endmodule

`default_nettype wire

[design/rrsi_iter.sv]
// Bit-per-stage pipeline: four restoring dividers for the slab parameters and a square root.
`default_nettype none

module rrsi_iter (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rrsi_pkg::prep_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rrsi_pkg::iter_type out_data
);
   import rrsi_pkg::*;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] acc;
   } lane_type;

   // Lanes 0 and 1 are the x slab edges, lanes 2 and 3 the y slab edges.
   typedef struct packed {
      ray_type                     ray;
      logic [3:0]                  n_neg;
      logic [3:0]                  n_zero;
      logic [1:0]                  d_neg;
      logic [1:0]                  d_zero;
      logic [1:0][DEN_W-1:0]       d_mag;
      lane_type [3:0]              lane;
      logic [SQ_W-1:0]             sq_rem;
      logic [SQ_W-1:0]             sq_root;
   } step_type;

   step_type          load;
   step_type          step_ff [QUO_W];
   step_type          step_in [QUO_W];
   step_type          src     [QUO_W];
   logic [QUO_W-1:0]  v_ff;
   logic [QUO_W:0]    en;

   always_comb begin
      load.ray     = in_data.ray;
      load.n_neg   = {in_data.sy.hi.neg, in_data.sy.lo.neg,
                      in_data.sx.hi.neg, in_data.sx.lo.neg};
      load.n_zero  = {in_data.sy.hi.zero, in_data.sy.lo.zero,
                      in_data.sx.hi.zero, in_data.sx.lo.zero};
      load.d_neg   = {in_data.sy.d_neg, in_data.sx.d_neg};
      load.d_zero  = {in_data.sy.d_zero, in_data.sx.d_zero};
      load.d_mag   = {in_data.sy.d_mag, in_data.sx.d_mag};
      load.lane[0] = '{rem: '0, acc: {in_data.sx.lo.mag, {Q_FRAC{1'b0}}}};
      load.lane[1] = '{rem: '0, acc: {in_data.sx.hi.mag, {Q_FRAC{1'b0}}}};
      load.lane[2] = '{rem: '0, acc: {in_data.sy.lo.mag, {Q_FRAC{1'b0}}}};
      load.lane[3] = '{rem: '0, acc: {in_data.sy.hi.mag, {Q_FRAC{1'b0}}}};
      load.sq_rem  = in_data.sq_sum;
      load.sq_root = '0;
   end

   assign en[QUO_W] = out_ready;
   assign in_ready  = en[0];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [SQ_W-1:0] sq_rem_nx, sq_root_nx;

      if (k == 0) begin : g_first
         assign src[k] = load;
      end else begin : g_next
         assign src[k] = step_ff[k-1];
      end

      // One root bit per stage while root bits remain, then the root just rides along.
      if (k < SQRT_STEPS) begin : g_sqrt
         localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
         always_comb begin
            logic [SQ_W-1:0] trial;
            trial = src[k].sq_root + SQ_BIT;
            if (src[k].sq_rem >= trial) begin
               sq_rem_nx  = src[k].sq_rem - trial;
               sq_root_nx = (src[k].sq_root >> 1) + SQ_BIT;
            end else begin
               sq_rem_nx  = src[k].sq_rem;
               sq_root_nx = src[k].sq_root >> 1;
            end
         end
      end else begin : g_hold
         assign sq_rem_nx  = src[k].sq_rem;
         assign sq_root_nx = src[k].sq_root;
      end

      always_comb begin
         logic [DEN_W:0] r2;
         logic [DEN_W:0] dd;
         logic           ge;
         step_in[k] = src[k];
         for (int l = 0; l < 4; l++) begin
            r2 = {src[k].lane[l].rem, src[k].lane[l].acc[QUO_W-1]};
            dd = {1'b0, src[k].d_mag[l/2]};
            ge = (r2 >= dd);
            step_in[k].lane[l].rem = ge ? DEN_W'(r2 - dd) : r2[DEN_W-1:0];
            step_in[k].lane[l].acc = {src[k].lane[l].acc[QUO_W-2:0], ge};
         end
         step_in[k].sq_rem  = sq_rem_nx;
         step_in[k].sq_root = sq_root_nx;
      end

      assign en[k] = !v_ff[k] || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[k-((k == 0) ? 0 : 1)];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            step_ff[k] <= step_in[k];
         end
      end
   end

   always_comb begin
      out_data.ray          = step_ff[QUO_W-1].ray;
      out_data.sx.lo.neg    = step_ff[QUO_W-1].n_neg[0];
      out_data.sx.lo.zero   = step_ff[QUO_W-1].n_zero[0];
      out_data.sx.lo.quo    = step_ff[QUO_W-1].lane[0].acc;
      out_data.sx.hi.neg    = step_ff[QUO_W-1].n_neg[1];
      out_data.sx.hi.zero   = step_ff[QUO_W-1].n_zero[1];
      out_data.sx.hi.quo    = step_ff[QUO_W-1].lane[1].acc;
      out_data.sx.d_neg     = step_ff[QUO_W-1].d_neg[0];
      out_data.sx.d_zero    = step_ff[QUO_W-1].d_zero[0];
      out_data.sy.lo.neg    = step_ff[QUO_W-1].n_neg[2];
      out_data.sy.lo.zero   = step_ff[QUO_W-1].n_zero[2];
      out_data.sy.lo.quo    = step_ff[QUO_W-1].lane[2].acc;
      out_data.sy.hi.neg    = step_ff[QUO_W-1].n_neg[3];
      out_data.sy.hi.zero   = step_ff[QUO_W-1].n_zero[3];
      out_data.sy.hi.quo    = step_ff[QUO_W-1].lane[3].acc;
      out_data.sy.d_neg     = step_ff[QUO_W-1].d_neg[1];
      out_data.sy.d_zero    = step_ff[QUO_W-1].d_zero[1];
      out_data.mag          = step_ff[QUO_W-1].sq_root[31:0];
   end

   assign out_valid = v_ff[QUO_W-1];

endmodule

`default_nettype wire

[design/rrsi_resolve.sv]
// Slab parameter signs, interval overlap, entry parameter and face normal selection.
`default_nettype none

module rrsi_resolve (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rrsi_pkg::iter_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rrsi_pkg::hit_type  out_data
);
   import rrsi_pkg::*;

   typedef struct packed {
      ray_type               ray;
      logic [31:0]           mag;
      logic                  undef;
      logic signed [T_W-1:0] a_x;
      logic signed [T_W-1:0] b_x;
      logic signed [T_W-1:0] a_y;
      logic signed [T_W-1:0] b_y;
   } par_type;

   typedef struct packed {
      ray_type               ray;
      logic [31:0]           mag;
      logic                  undef;
      logic signed [T_W-1:0] tn_x;
      logic signed [T_W-1:0] tf_x;
      logic signed [T_W-1:0] tn_y;
      logic signed [T_W-1:0] tf_y;
   } span_type;

   typedef struct packed {
      span_type s;
      logic     sep;
      logic     x_gt;
      logic     x_lt;
      logic     fx_lt;
   } cmp_type;

   // A zero direction sends the parameter to infinity on the numerator's side.
   function automatic logic signed [T_W-1:0] slab_t(input quo_type q, input logic d_neg,
                                                    input logic d_zero);
      logic signed [T_W-1:0] m;
      logic signed [T_W-1:0] r;
      m = $signed(T_W'(q.quo));
      if (d_zero) begin
         r = q.neg ? -T_INF : T_INF;
      end else begin
         r = (q.neg ^ d_neg) ? -m : m;
      end
      return r;
   endfunction

   logic     v1_ff, v2_ff, v3_ff, v4_ff;
   logic     en1, en2, en3, en4;
   par_type  p1_ff, p1_in;
   span_type p2_ff, p2_in;
   cmp_type  p3_ff, p3_in;
   hit_type  p4_ff, p4_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      p1_in.ray   = in_data.ray;
      p1_in.mag   = in_data.mag;
      p1_in.undef = (in_data.sx.d_zero && (in_data.sx.lo.zero || in_data.sx.hi.zero))
                 || (in_data.sy.d_zero && (in_data.sy.lo.zero || in_data.sy.hi.zero));
      p1_in.a_x   = slab_t(in_data.sx.lo, in_data.sx.d_neg, in_data.sx.d_zero);
      p1_in.b_x   = slab_t(in_data.sx.hi, in_data.sx.d_neg, in_data.sx.d_zero);
      p1_in.a_y   = slab_t(in_data.sy.lo, in_data.sy.d_neg, in_data.sy.d_zero);
      p1_in.b_y   = slab_t(in_data.sy.hi, in_data.sy.d_neg, in_data.sy.d_zero);
   end

   always_comb begin
      p2_in.ray   = p1_ff.ray;
      p2_in.mag   = p1_ff.mag;
      p2_in.undef = p1_ff.undef;
      if (p1_ff.a_x > p1_ff.b_x) begin
         p2_in.tn_x = p1_ff.b_x;
         p2_in.tf_x = p1_ff.a_x;
      end else begin
         p2_in.tn_x = p1_ff.a_x;
         p2_in.tf_x = p1_ff.b_x;
      end
      if (p1_ff.a_y > p1_ff.b_y) begin
         p2_in.tn_y = p1_ff.b_y;
         p2_in.tf_y = p1_ff.a_y;
      end else begin
         p2_in.tn_y = p1_ff.a_y;
         p2_in.tf_y = p1_ff.b_y;
      end
   end

   always_comb begin
      p3_in.s     = p2_ff;
      p3_in.sep   = (p2_ff.tn_x > p2_ff.tf_y) || (p2_ff.tn_y > p2_ff.tf_x);
      p3_in.x_gt  = p2_ff.tn_x > p2_ff.tn_y;
      p3_in.x_lt  = p2_ff.tn_x < p2_ff.tn_y;
      p3_in.fx_lt = p2_ff.tf_x < p2_ff.tf_y;
   end

   always_comb begin
      logic signed [T_W-1:0] tnear;
      logic signed [T_W-1:0] tfar;
      tnear = p3_ff.x_gt  ? p3_ff.s.tn_x : p3_ff.s.tn_y;
      tfar  = p3_ff.fx_lt ? p3_ff.s.tf_x : p3_ff.s.tf_y;
      p4_in.is_hit = !p3_ff.s.undef && !p3_ff.sep && !tfar[T_W-1] && !tnear[T_W-1];
      priority if (p3_ff.x_gt) begin
         p4_in.normal = p3_ff.s.ray.dir_x[31] ? NORM_POS_X : NORM_NEG_X;
      end else if (p3_ff.x_lt) begin
         p4_in.normal = p3_ff.s.ray.dir_y[31] ? NORM_POS_Y : NORM_NEG_Y;
      end else begin
         p4_in.normal = NORM_NONE;
      end
      p4_in.t   = sat32({{(64-T_W){tnear[T_W-1]}}, tnear});
      p4_in.ray = p3_ff.s.ray;
      p4_in.mag = p3_ff.s.mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p1_ff <= p1_in;
      end
      if (en2) begin
         p2_ff <= p2_in;
      end
      if (en3) begin
         p3_ff <= p3_in;
      end
      if (en4) begin
         p4_ff <= p4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = p4_ff;

endmodule

`default_nettype wire

[design/rrsi_finish.sv]
// Back stages: hit point, penetration depth and the output register.
`default_nettype none

module rrsi_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rrsi_pkg::hit_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rrsi_pkg::rsp_type out_data
);
   import rrsi_pkg::*;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] t;
      logic [2:0]         normal;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] pz;
      logic [31:0]        mag;
      logic signed [32:0] om;
   } prod_type;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] t;
      logic [2:0]         normal;
      logic signed [31:0] hx;
      logic signed [31:0] hy;
      logic signed [31:0] hz;
      logic signed [65:0] dprod;
   } sum_type;

   // Origin plus the product floored to Q16.16, clamped to 32 bits.
   function automatic logic signed [31:0] add_floor(input logic signed [31:0] o,
                                                    input logic signed [63:0] p);
      logic signed [63:0] s;
      s = {{32{o[31]}}, o} + {{Q_FRAC{p[63]}}, p[63:Q_FRAC]};
      return sat32(s);
   endfunction

   logic     v1_ff, v2_ff, out_valid_ff;
   logic     en1, en2, en3;
   prod_type f1_ff, f1_in;
   sum_type  f2_ff, f2_in;
   rsp_type  out_ff, out_in;

   assign en3      = !out_valid_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      logic signed [63:0] t64, dx, dy, dz;
      t64 = in_data.t;
      dx  = in_data.ray.dir_x;
      dy  = in_data.ray.dir_y;
      dz  = in_data.ray.dir_z;
      f1_in.is_hit = in_data.is_hit;
      f1_in.t      = in_data.t;
      f1_in.normal = in_data.normal;
      f1_in.ox     = in_data.ray.origin_x;
      f1_in.oy     = in_data.ray.origin_y;
      f1_in.oz     = in_data.ray.origin_z;
      f1_in.px     = dx * t64;
      f1_in.py     = dy * t64;
      f1_in.pz     = dz * t64;
      f1_in.mag    = in_data.mag;
      f1_in.om     = 33'sd65536 - {in_data.t[31], in_data.t};
   end

   always_comb begin
      logic signed [65:0] m66, o66;
      m66 = {34'b0, f1_ff.mag};
      o66 = {{33{f1_ff.om[32]}}, f1_ff.om};
      f2_in.is_hit = f1_ff.is_hit;
      f2_in.t      = f1_ff.t;
      f2_in.normal = f1_ff.normal;
      f2_in.hx     = add_floor(f1_ff.ox, f1_ff.px);
      f2_in.hy     = add_floor(f1_ff.oy, f1_ff.py);
      f2_in.hz     = add_floor(f1_ff.oz, f1_ff.pz);
      f2_in.dprod  = m66 * o66;
   end

   always_comb begin
      logic signed [49:0] dsh;
      dsh = f2_ff.dprod[65:Q_FRAC];
      if (f2_ff.is_hit) begin
         out_in.is_hit      = 1'b1;
         out_in.t_near      = f2_ff.t;
         out_in.hit_x       = f2_ff.hx;
         out_in.hit_y       = f2_ff.hy;
         out_in.hit_z       = f2_ff.hz;
         out_in.face_normal = f2_ff.normal;
         out_in.pen_depth   = sat32({{14{dsh[49]}}, dsh});
      end else begin
         out_in             = '0;
         out_in.face_normal = NORM_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            out_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         f1_ff <= f1_in;
      end
      if (en2) begin
         f2_ff <= f2_in;
      end
      if (en3) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

`include "ray_rect_slab_intersect_assert.svh"

   `RRSI_ASSERT_NOW(a_miss_zero, out_valid_ff && !out_ff.is_hit, out_ff.t_near == '0 && out_ff.hit_x == '0 && out_ff.hit_y == '0 && out_ff.hit_z == '0 && out_ff.face_normal == NORM_NONE && out_ff.pen_depth == '0, "miss transaction carries nonzero fields")
   `RRSI_ASSERT_NOW(a_hit_t_sign, out_valid_ff && out_ff.is_hit, !out_ff.t_near[31], "hit transaction with negative entry parameter")
   `RRSI_ASSERT_NOW(a_normal_hit, out_valid_ff && out_ff.face_normal != NORM_NONE, out_ff.is_hit, "face normal set on a miss")
   `RRSI_ASSERT_NEXT(a_stage_hold, v2_ff && !en3, v2_ff && $stable(f2_ff), "stalled stage lost its transaction")

endmodule

`default_nettype wire

[design/ray_rect_slab_intersect.sv]
// Top level of the pipelined ray versus axis-aligned rectangle slab test.
//
// A request transaction carries a ray (origin and direction, signed Q16.16) and a
// rectangle in the x-y plane; each request yields exactly one response transaction,
// in request order, with the hit flag, entry parameter, hit point, face normal code
// and penetration depth. A miss returns all fields zero.
// Both channels are valid/ready. One request can be taken every cycle while the
// pipeline is not stalled. From request acceptance to response valid a request
// passes 2 front stages, 49 stages of the bit-per-stage slab dividers (one quotient
// bit per stage, the direction length square root runs in the first 32 of them), 4
// resolve stages and 3 back stages ending in the output register.
// When the receiver holds rsp_ready low, the response stays in the output register
// and stages behind it keep filling empty slots until the pipeline is full; only then
// does req_ready fall. Synchronous reset empties the pipeline; no state is kept
// between transactions.
`default_nettype none

module ray_rect_slab_intersect (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrsi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrsi_pkg::rsp_type rsp_data
);
   import rrsi_pkg::*;

   logic     prep_valid, prep_ready;
   prep_type prep_data;
   logic     iter_valid, iter_ready;
   iter_type iter_data;
   logic     hit_valid, hit_ready;
   hit_type  hit_data;

   rrsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   rrsi_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (iter_valid),
      .out_ready (iter_ready),
      .out_data  (iter_data)
   );

   rrsi_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iter_valid),
      .in_ready  (iter_ready),
      .in_data   (iter_data),
      .out_valid (hit_valid),
      .out_ready (hit_ready),
      .out_data  (hit_data)
   );

   rrsi_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hit_valid),
      .in_ready  (hit_ready),
      .in_data   (hit_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire
